/* design/tacg_pkg.sv */
package tacg_pkg;

  localparam int MaxGrid   = 64;
  localparam int MaxWidth  = 4096;
  localparam int MaxHeight = 4096;
  localparam int GridW     = $clog2(MaxGrid);
  localparam int DimW      = $clog2(MaxWidth + 1);
  localparam int SumW      = 32;
  localparam int CntW      = 2 * DimW;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegGrid   = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [SumW-1:0] red;
    logic [SumW-1:0] green;
    logic [SumW-1:0] blue;
  } sums_t;

endpackage

/* design/tacg_sum_ram.sv */
module tacg_sum_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [tacg_pkg::GridW-1:0] waddr,
  input  tacg_pkg::sums_t           wdata,
  input  logic [tacg_pkg::GridW-1:0] raddr,
  output tacg_pkg::sums_t           rdata
);
  import tacg_pkg::*;

  sums_t mem [MaxGrid];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/tacg_div.sv */
module tacg_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [tacg_pkg::SumW-1:0] dividend,
  input  logic [tacg_pkg::CntW-1:0] divisor,
  output logic [7:0]                quotient,
  output logic                      busy
);
  import tacg_pkg::*;

  localparam int StepW = $clog2(SumW + 1);

  logic [SumW-1:0] num;
  logic [CntW:0]   rem;
  logic [CntW-1:0] den;
  logic [StepW-1:0] steps;
  logic [CntW:0]   trial;

  // restoring division, one quotient bit a cycle
  assign trial = {rem[CntW-1:0], num[SumW-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      num   <= dividend;
      den   <= divisor;
      rem   <= '0;
      steps <= StepW'(SumW);
    end else if (busy) begin
      if (!trial[CntW]) begin
        rem <= trial;
      end else begin
        rem <= {rem[CntW-1:0], num[SumW-1]};
      end
      num   <= {num[SumW-2:0], ~trial[CntW]};
      steps <= steps - 1'b1;
      if (steps == StepW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient = num[7:0];

endmodule

/* design/tile_average_color_grid_top.sv */
// Tile average colour grid: pixels come in raster order on pix_*, one word per
// accepted handshake, and the frame is cut into grid_count x grid_count tiles
// with edges at width*b/grid and height*a/grid. Per-column channel sums for the
// current band live in a 64-entry synchronous RAM. Each pixel takes a read and
// a write-back; a pixel that closes a tile also starts the 32-step bit-serial
// divider, one per channel with all three running side by side. A finished tile
// waits in the result register while pixels keep flowing; only the next tile to
// close stalls until it is taken. After reset and after every configuration
// write the RAM is swept to zero, one entry a cycle, while width/grid and
// height/grid are found by repeated subtraction; no pixel is accepted until both
// have finished. Any register write restarts the frame; writes beyond the
// register list are ignored, and no pixel is taken while a configuration word is
// offered.
module tile_average_color_grid_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  pix_blue,
  input  logic [7:0]  pix_green,
  input  logic [7:0]  pix_red,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  tile_row,
  output logic [5:0]  tile_col,
  output logic [7:0]  avg_red,
  output logic [7:0]  avg_green,
  output logic [7:0]  avg_blue,
  output logic        frame_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import tacg_pkg::*;

  // configuration
  logic [12:0] image_width, image_height;
  logic [6:0]  grid_count;
  logic [DimW-1:0] w_eff, h_eff;
  logic [GridW:0]  g_eff;

  // position
  state_t state, state_next;
  logic [DimW-1:0] pixel_column, pixel_row;
  logic [GridW-1:0] cur_col, cur_band;
  logic [GridW-1:0] clr_idx;

  // boundaries, kept up to date incrementally (edge = dim*k/g)
  logic [DimW-1:0] col_hi, col_lo, row_hi, row_lo;
  logic [DimW-1:0] col_acc, row_acc; // remainders of dim*k mod g

  logic [7:0] px_r, px_g, px_b;
  sums_t rdata, wdata;
  logic  we;
  logic [GridW-1:0] waddr;
  logic  tile_end;
  logic [CntW-1:0] count;
  logic  div_start;
  logic  busy_r, busy_g, busy_b;
  logic [7:0] q_r, q_g, q_b;
  logic  cfg_hit;

  assign cfg_ready = (state == ST_IDLE) || (state == ST_CLEAR);
  assign cfg_hit   = cfg_valid && cfg_ready && (cfg_index == RegWidth ||
                     cfg_index == RegHeight || cfg_index == RegGrid);
  assign in_ready  = (state == ST_IDLE) && !cfg_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 13'd640;
      image_height <= 13'd480;
      grid_count   <= 7'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegWidth:  image_width  <= cfg_data;
        RegHeight: image_height <= cfg_data;
        RegGrid:   grid_count   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // clamped dimensions
  always_comb begin
    logic [GridW:0] g;
    w_eff = (image_width == '0) ? DimW'(1) :
            (image_width > 13'(MaxWidth)) ? DimW'(MaxWidth) : image_width[DimW-1:0];
    h_eff = (image_height == '0) ? DimW'(1) :
            (image_height > 13'(MaxHeight)) ? DimW'(MaxHeight) : image_height[DimW-1:0];
    g = (grid_count == '0) ? (GridW+1)'(1) :
        (grid_count > 7'(MaxGrid)) ? (GridW+1)'(MaxGrid) : grid_count[GridW:0];
    if (DimW'(g) > w_eff) g = w_eff[GridW:0];
    if (DimW'(g) > h_eff) g = h_eff[GridW:0];
    g_eff = g;
  end

  // next edge: step by floor(dim/g) with remainder carry; dim/g by small loop
  // would be a divider, so the quotient and remainder are precomputed on restart
  logic [DimW-1:0] w_q, w_r, h_q, h_r;
  logic [DimW-1:0] dq_num, dq_q, dq_r;
  logic [GridW:0]  dq_step;
  logic            dq_h;

  function automatic logic [2*DimW-1:0] adv(input logic [DimW-1:0] hi,
      input logic [DimW-1:0] acc, input logic [DimW-1:0] q,
      input logic [DimW-1:0] r, input logic [GridW:0] g);
    logic [DimW:0] s;
    logic [DimW-1:0] h2;
    s  = {1'b0, acc} + {1'b0, r};
    h2 = hi + q;
    if (s >= (DimW+1)'(g)) begin
      s  = s - (DimW+1)'(g);
      h2 = h2 + 1'b1;
    end
    return {h2, s[DimW-1:0]};
  endfunction

  assign tile_end = (pixel_column + 1'b1 == col_hi) && (pixel_row + 1'b1 == row_hi);
  assign count    = CntW'(col_hi - col_lo) * CntW'(row_hi - row_lo);

  tacg_sum_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cur_col),
    .rdata (rdata)
  );

  sums_t acc;
  assign acc.red   = rdata.red   + SumW'(px_r);
  assign acc.green = rdata.green + SumW'(px_g);
  assign acc.blue  = rdata.blue  + SumW'(px_b);

  tacg_div u_div_r (.clk, .rst, .start(div_start), .dividend(acc.red),
                    .divisor(count), .quotient(q_r), .busy(busy_r));
  tacg_div u_div_g (.clk, .rst, .start(div_start), .dividend(acc.green),
                    .divisor(count), .quotient(q_g), .busy(busy_g));
  tacg_div u_div_b (.clk, .rst, .start(div_start), .dividend(acc.blue),
                    .divisor(count), .quotient(q_b), .busy(busy_b));

  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = cur_col;
    wdata      = acc;
    div_start  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_idx;
        wdata = '0;
        if (clr_idx == GridW'(MaxGrid - 1) && dq_step == '0) state_next = ST_IDLE;
      end
      ST_IDLE: if (in_valid && in_ready) state_next = ST_READ;
      ST_READ: begin
        we = 1'b1;
        if (tile_end) begin
          wdata      = '0;
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_IDLE;
        end
      end
      // wait for the dividers, then hold the quotients until the result register is free
      ST_DIV: if (!busy_r && !busy_g && !busy_b && (!out_valid || out_ready)) begin
        state_next = ST_OUT;
      end
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_CLEAR;
    endcase
    if (cfg_hit) state_next = ST_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // restart: clear sweep plus serial computation of dim/g
  logic restart;
  assign restart = rst || cfg_hit;

  always_ff @(posedge clk) begin
    if (restart) begin
      clr_idx <= '0;
      dq_step <= (GridW+1)'(1);
      dq_h    <= 1'b0;
      dq_num  <= '0;
      dq_q    <= '0;
    end else if (state == ST_CLEAR) begin
      if (clr_idx != GridW'(MaxGrid - 1)) clr_idx <= clr_idx + 1'b1;
      // repeated subtraction, width/grid first, then height/grid
      if (dq_step != '0) begin
        if (dq_step == (GridW+1)'(1) && dq_num == '0 && dq_q == '0) begin
          dq_num  <= dq_h ? h_eff : w_eff;
          dq_step <= (GridW+1)'(2);
        end else if (dq_num >= DimW'(g_eff)) begin
          dq_num <= dq_num - DimW'(g_eff);
          dq_q   <= dq_q + 1'b1;
        end else begin
          if (!dq_h) begin
            w_q     <= dq_q;
            w_r     <= dq_num;
            dq_h    <= 1'b1;
            dq_q    <= '0;
            dq_num  <= '0;
            dq_step <= (GridW+1)'(1);
          end else begin
            h_q     <= dq_q;
            h_r     <= dq_num;
            dq_step <= '0;
          end
        end
      end
    end
  end

  // position and edges
  always_ff @(posedge clk) begin
    logic [2*DimW-1:0] nc, nr;
    nc = adv(col_hi, col_acc, w_q, w_r, g_eff);
    nr = adv(row_hi, row_acc, h_q, h_r, g_eff);
    if (state == ST_CLEAR) begin
      pixel_column <= '0;
      pixel_row    <= '0;
      cur_col      <= '0;
      cur_band     <= '0;
      col_lo       <= '0;
      row_lo       <= '0;
      col_hi       <= w_q + DimW'(w_r >= DimW'(g_eff));
      row_hi       <= h_q + DimW'(h_r >= DimW'(g_eff));
      col_acc      <= w_r;
      row_acc      <= h_r;
    end else if (state == ST_IDLE && in_valid && in_ready) begin
      px_r <= pix_red;
      px_g <= pix_green;
      px_b <= pix_blue;
    end else if (state == ST_READ && !tile_end || state == ST_OUT) begin
      if (pixel_column + 1'b1 >= w_eff) begin
        pixel_column <= '0;
        cur_col      <= '0;
        col_lo       <= '0;
        col_hi       <= w_q;
        col_acc      <= w_r;
        if (pixel_row + 1'b1 >= h_eff) begin
          pixel_row <= '0;
          cur_band  <= '0;
          row_lo    <= '0;
          row_hi    <= h_q;
          row_acc   <= h_r;
        end else begin
          pixel_row <= pixel_row + 1'b1;
          if (pixel_row + 1'b1 == row_hi) begin
            cur_band <= cur_band + 1'b1;
            row_lo   <= row_hi;
            row_hi   <= nr[2*DimW-1:DimW];
            row_acc  <= nr[DimW-1:0];
          end
        end
      end else begin
        pixel_column <= pixel_column + 1'b1;
        if (pixel_column + 1'b1 == col_hi) begin
          cur_col <= cur_col + 1'b1;
          col_lo  <= col_hi;
          col_hi  <= nc[2*DimW-1:DimW];
          col_acc <= nc[DimW-1:0];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT) begin
      out_valid  <= 1'b1;
      tile_row   <= cur_band;
      tile_col   <= cur_col;
      avg_red    <= q_r;
      avg_green  <= q_g;
      avg_blue   <= q_b;
      frame_done <= (cur_band + 1'b1 == g_eff[GridW-1:0] || g_eff == (GridW+1)'(MaxGrid) &&
                     cur_band == '1) &&
                    (cur_col + 1'b1 == g_eff[GridW-1:0] || g_eff == (GridW+1)'(MaxGrid) &&
                     cur_col == '1);
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_no_take_while_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> state == ST_IDLE)
    else $error("pixel taken while busy");
  a_div_then_out: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT |-> !busy_r && !busy_g && !busy_b)
    else $error("result before division done");
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT |-> !out_valid)
    else $error("waiting tile overwritten");
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> pixel_column < w_eff && pixel_row < h_eff)
    else $error("position outside frame");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import tacg_pkg::*;

  // index past the end of the register list, the block ignores it
  localparam logic [1:0] RegUnused = 2'd3;
  localparam int CyclesLimit = 1000000;
  localparam int DrainCycles = 100;
  localparam int HoldCycles  = 400;

  typedef struct packed {
    logic [5:0] row;
    logic [5:0] col;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } tile_avg_t;

  // one row of the directed table; typed rows carry their answer directly
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       typed;
  } pix_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  pix_blue;
  logic [7:0]  pix_green;
  logic [7:0]  pix_red;
  logic        out_valid;
  logic        out_ready;
  logic [5:0]  tile_row;
  logic [5:0]  tile_col;
  logic [7:0]  avg_red;
  logic [7:0]  avg_green;
  logic [7:0]  avg_blue;
  logic        frame_done;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;

  tile_average_color_grid_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pix_blue   (pix_blue),
    .pix_green  (pix_green),
    .pix_red    (pix_red),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .tile_row   (tile_row),
    .tile_col   (tile_col),
    .avg_red    (avg_red),
    .avg_green  (avg_green),
    .avg_blue   (avg_blue),
    .frame_done (frame_done),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // shadow copy of the block: registers, per-column sums and position
  logic [12:0] mdl_width;
  logic [12:0] mdl_height;
  logic [6:0]  mdl_grid;
  int unsigned sum_red   [MaxGrid];
  int unsigned sum_green [MaxGrid];
  int unsigned sum_blue  [MaxGrid];
  int unsigned pos_x, pos_y, pos_col, pos_band;

  tile_avg_t   tile_queue[$];
  int          errors = 0;
  int          cycles = 0;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_request;
  bit          hold_taken = 1'b0;
  int          hold_left = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CyclesLimit) begin
      $display("%0t: run timed out", $time);
      $display("tile_average_color_grid_top: mismatch");
      $finish;
    end
  end

  // frame restart: position back to the top-left, every column sum cleared
  task automatic restart_frame();
    for (int i = 0; i < MaxGrid; i++) begin
      sum_red[i]   = 0;
      sum_green[i] = 0;
      sum_blue[i]  = 0;
    end
    pos_x = 0;
    pos_y = 0;
    pos_col = 0;
    pos_band = 0;
  endtask

  task automatic shadow_cfg_write(input logic [1:0] idx, input logic [12:0] data);
    case (idx)
      RegWidth: begin
        mdl_width = data;
      end
      RegHeight: begin
        mdl_height = data;
      end
      RegGrid: begin
        mdl_grid = data[6:0];
      end
      default: begin
        return;
      end
    endcase
    restart_frame();
  endtask

  function automatic int unsigned clamp_range(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // accumulate one pixel; flags a finished tile and works out its averages
  task automatic accumulate_pixel(input logic [7:0] b, input logic [7:0] g,
                                  input logic [7:0] r, output bit done,
                                  output tile_avg_t avg);
    int unsigned w, h, n, x, y, c, band, clo, chi, rlo, rhi, count;
    w = clamp_range(mdl_width, MaxWidth);
    h = clamp_range(mdl_height, MaxHeight);
    n = clamp_range(mdl_grid, MaxGrid);
    done = 1'b0;
    avg = '0;
    // more tiles than pixels along a side: shrink the grid
    if (n > w) n = w;
    if (n > h) n = h;
    if (pos_x >= w || pos_y >= h || pos_col >= n || pos_band >= n) restart_frame();
    x = pos_x;
    y = pos_y;
    c = pos_col;
    band = pos_band;
    sum_red[c]   += r;
    sum_green[c] += g;
    sum_blue[c]  += b;
    clo = (w * c) / n;
    chi = (w * (c + 1)) / n;
    rlo = (h * band) / n;
    rhi = (h * (band + 1)) / n;
    if (x + 1 == chi && y + 1 == rhi) begin
      count = (chi - clo) * (rhi - rlo);
      if (count == 0) count = 1;
      avg.row   = band[5:0];
      avg.col   = c[5:0];
      avg.red   = 8'(sum_red[c] / count);
      avg.green = 8'(sum_green[c] / count);
      avg.blue  = 8'(sum_blue[c] / count);
      avg.last  = (band + 1 == n) && (c + 1 == n);
      sum_red[c]   = 0;
      sum_green[c] = 0;
      sum_blue[c]  = 0;
      done = 1'b1;
    end
    // step to the next pixel, wrapping at row and frame end
    if (x + 1 == chi) c++;
    x++;
    if (x >= w) begin
      x = 0;
      c = 0;
      if (y + 1 == rhi) band++;
      y++;
      if (y >= h) begin
        y = 0;
        band = 0;
      end
    end
    if (c >= n) c = 0;
    if (band >= n) band = 0;
    pos_x = x;
    pos_y = y;
    pos_col = c;
    pos_band = band;
  endtask

  // sender: optional idle cycles, then hold the word until the handshake
  task automatic send_pixel(input logic [7:0] b, input logic [7:0] g,
                            input logic [7:0] r, input bit typed);
    bit        done;
    tile_avg_t avg;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    pix_blue  = b;
    pix_green = g;
    pix_red   = r;
    do @(posedge clk); while (!in_ready);
    accumulate_pixel(b, g, r, done, avg);
    // typed rows: a 1x1 frame, so the tile average is the pixel itself
    if (typed) tile_queue.push_back('{6'd0, 6'd0, r, g, b, 1'b1});
    else if (done) tile_queue.push_back(avg);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // wait for every pending tile, then for the block to settle
  task automatic drain();
    while (tile_queue.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    shadow_cfg_write(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_frame(input logic [12:0] w, input logic [12:0] h, input logic [12:0] n);
    drain();
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
    write_reg(RegGrid, n);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++)
      send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 1'b0);
  endtask

  task automatic set_idling(input int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
      default: begin send_idle_pct = 32; recv_stall_pct = 32; end
    endcase
  endtask

  // receiver: random stalls, plus one long hold-off counted here
  always @(negedge clk) begin
    if (hold_request && !hold_taken) begin
      hold_left = HoldCycles;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker, sampled on the rising edge
  always @(posedge clk) begin
    tile_avg_t exp_avg;
    if (!rst && out_valid && out_ready) begin
      if (tile_queue.size() == 0) begin
        $display("%0t: tile word with none expected (row %0d col %0d)",
                 $time, tile_row, tile_col);
        errors++;
      end else begin
        exp_avg = tile_queue.pop_front();
        if (tile_row !== exp_avg.row) begin
          $display("%0t: tile_row exp %0d got %0d", $time, exp_avg.row, tile_row);
          errors++;
        end
        if (tile_col !== exp_avg.col) begin
          $display("%0t: tile_col exp %0d got %0d", $time, exp_avg.col, tile_col);
          errors++;
        end
        if (avg_red !== exp_avg.red) begin
          $display("%0t: avg_red exp %0d got %0d", $time, exp_avg.red, avg_red);
          errors++;
        end
        if (avg_green !== exp_avg.green) begin
          $display("%0t: avg_green exp %0d got %0d", $time, exp_avg.green, avg_green);
          errors++;
        end
        if (avg_blue !== exp_avg.blue) begin
          $display("%0t: avg_blue exp %0d got %0d", $time, exp_avg.blue, avg_blue);
          errors++;
        end
        if (frame_done !== exp_avg.last) begin
          $display("%0t: frame_done exp %0d got %0d", $time, exp_avg.last, frame_done);
          errors++;
        end
      end
    end
  end

  // directed rows on a 1x1 frame: extremes and alternating bit patterns
  pix_row_t single_rows[8] = '{
    '{8'h00, 8'h00, 8'h00, 1'b1},
    '{8'hff, 8'hff, 8'hff, 1'b1},
    '{8'haa, 8'h55, 8'h0f, 1'b1},
    '{8'h55, 8'haa, 8'hf0, 1'b1},
    '{8'h01, 8'h80, 8'h7f, 1'b1},
    '{8'hfe, 8'h7f, 8'h80, 1'b1},
    '{8'h00, 8'hff, 8'h00, 1'b1},
    '{8'hff, 8'h00, 8'hff, 1'b1}
  };

  initial begin
    int sent;
    int phase;
    rst = 1'b1;
    in_valid = 1'b0;
    pix_blue = '0;
    pix_green = '0;
    pix_red = '0;
    cfg_valid = 1'b0;
    cfg_index = RegWidth;
    cfg_data = '0;
    hold_request = 1'b0;
    set_idling(0);
    mdl_width = 13'd640;
    mdl_height = 13'd480;
    mdl_grid = 7'd1;
    restart_frame();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset frame is 640x480 in one tile: a few pixels give no word
    send_random(3);

    // single-pixel frame, every word is the pixel itself
    set_frame(13'd1, 13'd1, 13'd1);
    foreach (single_rows[i])
      send_pixel(single_rows[i].blue, single_rows[i].green, single_rows[i].red,
                 single_rows[i].typed);

    // zero sizes are taken as one
    set_frame(13'd0, 13'd0, 13'd0);
    send_random(3);
    // grid saturates to 64, then clamps to the 3x2 frame
    set_frame(13'd3, 13'd2, 13'd127);
    send_random(12);
    // out-of-list write is ignored and does not restart the frame
    send_random(2);
    drain();
    write_reg(RegUnused, 13'h1fff);
    send_random(4);
    // widest row saturates to 4096; a single row clamps the grid to one tile
    set_frame(13'h1fff, 13'd1, 13'd64);
    send_random(260);
    // tallest column, one pixel wide
    set_frame(13'd1, 13'h1fff, 13'd64);
    send_random(130);
    // uneven tile edges
    set_frame(13'd5, 13'd7, 13'd3);
    send_random(40);

    // random frames, idling changes per phase, one long output hold-off
    sent = 0;
    phase = 0;
    while (sent < 588) begin
      int n;
      // hold-off phase: every pixel closes a tile, so the block fills up
      if (phase == 2) begin
        set_frame(13'd4, 13'd4, 13'd4);
      end else begin
        set_frame(13'($urandom_range(1, 12)), 13'($urandom_range(1, 12)),
                  ($urandom_range(3) == 0) ? 13'($urandom_range(0, 127)) :
                                             13'($urandom_range(0, 4)));
      end
      set_idling(phase);
      if (phase == 2) begin
        set_idling(0);
        hold_request = 1'b1;
      end
      n = $urandom_range(30, 90);
      send_random(n);
      sent += n;
      phase++;
    end
    set_idling(0);

    while (tile_queue.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (errors == 0) begin
      $display("tile_average_color_grid_top: match");
    end else begin
      $display("tile_average_color_grid_top: mismatch");
    end
    $finish;
  end

endmodule
